>>> src/btrq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus transfer request queue: shared definitions
// Types, codes and stream widths used by the queue's controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package btrq_pkg;

	localparam int QUEUE_DEPTH_DEF = 8;

	// Stream widths
	localparam int S_TDATA_W = 88;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 88;
	localparam int M_TUSER_W = 2;

	// Input actions
	localparam logic [2:0] ACT_ADD_BACK  = 3'd0;
	localparam logic [2:0] ACT_ADD_FRONT = 3'd1;
	localparam logic [2:0] ACT_DONE_OK   = 3'd2;
	localparam logic [2:0] ACT_DONE_ERR  = 3'd3;
	localparam logic [2:0] ACT_START_REJ = 3'd4;

	// Result kinds
	localparam logic [1:0] RK_ACK    = 2'd0;
	localparam logic [1:0] RK_ISSUE  = 2'd1;
	localparam logic [1:0] RK_REPORT = 2'd2;

	// Request kinds
	localparam logic [1:0] KIND_MEM_READ = 2'd0;
	localparam logic [1:0] KIND_TRANSMIT = 2'd1;

	// Completion status
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_ERROR = 2'd1;

	typedef struct packed {
		logic [1:0]  req_kind;
		logic [1:0]  bus_id;
		logic [1:0]  mem_addr_bytes;
		logic [15:0] mem_addr;
		logic [9:0]  dev_addr;
	} addr_word_t;

	typedef struct packed {
		logic        notify;
		logic [15:0] context_tag;
		logic [15:0] length;
		logic [15:0] buffer_ref;
	} xfer_word_t;

	typedef struct packed {
		addr_word_t a;
		xfer_word_t x;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [2:0] action;
		logic [1:0] start_status;
		entry_t     ent;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic        accepted;
		logic [1:0]  out_bus_id;
		logic        out_kind;
		logic [9:0]  out_dev_addr;
		logic [15:0] out_mem_addr;
		logic [1:0]  out_mem_addr_bytes;
		logic [15:0] out_buffer_ref;
		logic [15:0] out_length;
		logic [15:0] out_context_tag;
		logic [1:0]  out_status;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DREAD,
		ST_DTAKE,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic cap;
		logic exec;
		logic rd;
		logic take;
		logic flush;
	} ctrl_cmd_t;

	typedef struct packed {
		logic can_dispatch;
		logic take_stall;
		logic pend_valid;
		logic out_free;
	} dp_stat_t;

endpackage

>>> src/btrq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module btrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/btrq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request queue controller
// Sequences capture, execution, dispatch and the final flush of one item.
// ----------------------------------------------------------------------------
module btrq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  btrq_pkg::dp_stat_t   stat,
	output btrq_pkg::ctrl_cmd_t  cmd
);

	import btrq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_DREAD;
			end
			ST_DREAD: begin
				if (stat.can_dispatch) begin
					cmd.rd  = 1'b1;
					state_d = ST_DTAKE;
				end else begin
					state_d = ST_FLUSH;
				end
			end
			ST_DTAKE: begin
				// hold while the held result cannot move to the output
				if (!stat.take_stall) begin
					cmd.take = 1'b1;
					state_d  = ST_DREAD;
				end
			end
			ST_FLUSH: begin
				if (!stat.pend_valid) begin
					state_d = ST_IDLE;
				end else if (stat.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> src/btrq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request queue datapath
// Ring of waiting requests, in-flight slot, held result and output register.
// ----------------------------------------------------------------------------
module btrq_dp #(
	parameter int QUEUE_DEPTH = btrq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  btrq_pkg::in_item_t   in_item,
	input  btrq_pkg::ctrl_cmd_t  cmd,
	output btrq_pkg::dp_stat_t   stat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output btrq_pkg::result_t    out_res,
	output logic                 out_last
);

	import btrq_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	in_item_t         in_q;
	entry_t           infl_q;
	logic             infl_valid_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	result_t          pend_q;
	logic             pend_valid_q;
	result_t          out_q;
	logic             out_last_q;
	logic             out_valid_q;

	logic [PTR_W-1:0] head_nx;
	logic [PTR_W-1:0] tail_nx;
	logic [PTR_W-1:0] tail_prev;
	logic             is_back;
	logic             is_add;
	logic             add_ok;
	logic             is_event;
	logic             ev_match;
	logic [1:0]       ev_status;
	entry_t           rd_ent;
	logic             rd_ok;
	logic             new_res;
	result_t          res_new;
	logic             push;
	logic             out_free;

	logic               ram_we;
	logic [PTR_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_rdata;

	btrq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (in_q.ent),
		.re    (cmd.rd),
		.raddr (tail_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		head_nx   = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
		tail_nx   = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
		tail_prev = (tail_q == '0) ? PTR_LAST : tail_q - 1'b1;

		is_back  = (in_q.action == ACT_ADD_BACK);
		is_add   = is_back || (in_q.action == ACT_ADD_FRONT);
		add_ok   = is_back ? (head_nx != tail_q) : (tail_prev != head_q);
		is_event = (in_q.action == ACT_DONE_OK) || (in_q.action == ACT_DONE_ERR) ||
			(in_q.action == ACT_START_REJ);
		ev_match = is_event && infl_valid_q && (infl_q.a.bus_id == in_q.ent.a.bus_id);

		priority if (in_q.action == ACT_DONE_OK) begin
			ev_status = STAT_OK;
		end else if (in_q.action == ACT_DONE_ERR) begin
			ev_status = STAT_ERROR;
		end else if (in_q.start_status == STAT_OK) begin
			ev_status = STAT_ERROR;
		end else begin
			ev_status = in_q.start_status;
		end

		rd_ent = entry_t'(ram_rdata);
		rd_ok  = (rd_ent.a.req_kind <= KIND_TRANSMIT);

		new_res = 1'b0;
		res_new = '0;
		if (cmd.exec) begin
			if (is_add) begin
				new_res          = 1'b1;
				res_new.result_kind = RK_ACK;
				res_new.accepted = add_ok;
			end else if (ev_match && infl_q.x.notify) begin
				new_res                 = 1'b1;
				res_new.result_kind     = RK_REPORT;
				res_new.out_context_tag = infl_q.x.context_tag;
				res_new.out_status      = ev_status;
			end
		end else if (cmd.take) begin
			if (rd_ok) begin
				new_res                    = 1'b1;
				res_new.result_kind        = RK_ISSUE;
				res_new.out_bus_id         = rd_ent.a.bus_id;
				res_new.out_kind           = rd_ent.a.req_kind[0];
				res_new.out_dev_addr       = rd_ent.a.dev_addr;
				res_new.out_mem_addr       = rd_ent.a.mem_addr;
				res_new.out_mem_addr_bytes = rd_ent.a.mem_addr_bytes;
				res_new.out_buffer_ref     = rd_ent.x.buffer_ref;
				res_new.out_length         = rd_ent.x.length;
			end else if (rd_ent.x.notify) begin
				new_res                 = 1'b1;
				res_new.result_kind     = RK_REPORT;
				res_new.out_context_tag = rd_ent.x.context_tag;
				res_new.out_status      = STAT_ERROR;
			end
		end

		ram_we    = cmd.exec && is_add && add_ok;
		ram_waddr = is_back ? head_q : tail_prev;

		out_free = !out_valid_q || out_ready;
		push     = (new_res && pend_valid_q) || cmd.flush;

		stat.can_dispatch = !infl_valid_q && (head_q != tail_q);
		stat.take_stall   = pend_valid_q && !out_free;
		stat.pend_valid   = pend_valid_q;
		stat.out_free     = out_free;
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			in_q <= in_item;
		end
		if (cmd.take && rd_ok) begin
			infl_q <= rd_ent;
		end
		if (new_res) begin
			pend_q <= res_new;
		end
		if (push) begin
			out_q      <= pend_q;
			out_last_q <= cmd.flush;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			infl_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (ram_we) begin
				if (is_back) begin
					head_q <= head_nx;
				end else begin
					tail_q <= tail_prev;
				end
			end else if (cmd.take) begin
				tail_q <= tail_nx;
			end
			if (cmd.exec && ev_match) begin
				infl_valid_q <= 1'b0;
			end else if (cmd.take && rd_ok) begin
				infl_valid_q <= 1'b1;
			end
			if (new_res) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign out_last  = out_last_q;

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q <= PTR_LAST) && (tail_q <= PTR_LAST))
		else $error("ring pointer out of range");

	a_rd_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> (!infl_valid_q && (head_q != tail_q)))
		else $error("ring read while busy or empty");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (out_free && pend_valid_q))
		else $error("output register overwritten");

	a_cap_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap |-> !pend_valid_q)
		else $error("new item taken with a result still held");

endmodule

>>> src/bus_transfer_request_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus transfer request queue
// Ring of serial-bus transfer requests with back/front add, one in-flight
// request and completion reporting.
// ----------------------------------------------------------------------------
// Items are handled one at a time: a new transfer is taken only once the
//   previous item has been executed, dispatched and flushed. Output stalls
//   hold it up; the RAM's registered read paces each dispatch step.
// Reset: arst_n clears the pointers, the in-flight slot and the output;
//   ring contents are not cleared and are never read before written.
// ----------------------------------------------------------------------------
module bus_transfer_request_queue #(
	parameter int QUEUE_DEPTH = btrq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// bus_id[1:0], req_kind[3:2], dev_addr[13:4], mem_addr[29:14],
	// mem_addr_bytes[31:30], buffer_ref[47:32], length[63:48], notify[64],
	// context_tag[80:65], start_status[82:81], zero fill above
	input  logic [btrq_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// action[2:0]
	input  logic [btrq_pkg::S_TUSER_W-1:0] s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// accepted[0], out_bus_id[2:1], out_kind[3], out_dev_addr[13:4],
	// out_mem_addr[29:14], out_mem_addr_bytes[31:30], out_buffer_ref[47:32],
	// out_length[63:48], out_context_tag[79:64], out_status[81:80], zeros above
	output logic [btrq_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// result_kind[1:0]
	output logic [btrq_pkg::M_TUSER_W-1:0] m_axis_tuser,
	output logic                           m_axis_tlast
);

	import btrq_pkg::*;

	in_item_t  in_item;
	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	result_t   res;
	logic      res_last;

	// Unpack the request or event from the slave-side transfer
	always_comb begin
		in_item.action             = s_axis_tuser;
		in_item.ent.a.bus_id       = s_axis_tdata[1:0];
		in_item.ent.a.req_kind     = s_axis_tdata[3:2];
		in_item.ent.a.dev_addr     = s_axis_tdata[13:4];
		in_item.ent.a.mem_addr     = s_axis_tdata[29:14];
		in_item.ent.a.mem_addr_bytes = s_axis_tdata[31:30];
		in_item.ent.x.buffer_ref   = s_axis_tdata[47:32];
		in_item.ent.x.length       = s_axis_tdata[63:48];
		in_item.ent.x.notify       = s_axis_tdata[64];
		in_item.ent.x.context_tag  = s_axis_tdata[80:65];
		in_item.start_status       = s_axis_tdata[82:81];
	end

	// Controller: one item at a time, through execute, dispatch and flush
	btrq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: ring, in-flight slot and output register; a result is held
	// one step so the final one of an item leaves with tlast set
	btrq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res),
		.out_last  (res_last)
	);

	// Pack the result onto the master-side transfer
	always_comb begin
		m_axis_tdata        = '0;
		m_axis_tdata[0]     = res.accepted;
		m_axis_tdata[2:1]   = res.out_bus_id;
		m_axis_tdata[3]     = res.out_kind;
		m_axis_tdata[13:4]  = res.out_dev_addr;
		m_axis_tdata[29:14] = res.out_mem_addr;
		m_axis_tdata[31:30] = res.out_mem_addr_bytes;
		m_axis_tdata[47:32] = res.out_buffer_ref;
		m_axis_tdata[63:48] = res.out_length;
		m_axis_tdata[79:64] = res.out_context_tag;
		m_axis_tdata[81:80] = res.out_status;
		m_axis_tuser        = res.result_kind;
		m_axis_tlast        = res_last;
	end

endmodule
